[rtl/rgqb_pkg.sv]
`default_nettype none
package rgqb_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STEP  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_W      = 7;
    localparam int FIELD_IDX_W = 6;
    localparam int DRAW_W     = 16;
    localparam int IN_WGT_W   = 16;
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

endpackage
`default_nettype wire

[rtl/randomized_greedy_qubo_builder_top.sv]
// Randomized greedy QUBO construction engine.
// Input beats on s_* (tuser = command): weight write, start, greedy step.
// Every input beat yields exactly one result beat on m_*: chosen variable,
// its value, tlast when every variable is assigned, tuser = command accepted.
// cfg_* writes problem_size (latched at start); cfg_ready is always high.
// One command at a time; the single read port of the weight memory is
// walked row by row on start and column-wise on each fix.
// A finished result sits in the output register; the next input beat is
// taken while it waits, and work stops before a second result would need
// the register until the receiver takes the first.
// After reset the weight memory is cleared one entry per cycle, all
// 2^(2*clog2(MAX_VARS)) entries (4096 by default), with s_tready low.
// Reset also clears assignment flags and marks the construction not started.
`default_nettype none
module randomized_greedy_qubo_builder_top #(
    parameter int MAX_VARS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // row[5:0] col[11:6] weight[27:12] start_index[33:28] start_value[34] rand_draw[50:35]
    input  wire  [rgqb_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire  [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // chosen_index[5:0] chosen_value[6]
    output logic [rgqb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // accepted[0]
    output logic [0:0]                         m_tuser,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [rgqb_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W   = $clog2(MAX_VARS);
    localparam int CNT_W   = $clog2(MAX_VARS + 1);
    localparam int WADDR_W = 2 * IDX_W;
    localparam int WDEPTH  = 1 << WADDR_W;
    localparam int GDEPTH  = 1 << IDX_W;
    localparam int GAIN_W  = WEIGHT_BITS + IDX_W + 4;
    localparam int S_W     = GAIN_W + 1;
    localparam int P_W     = S_W + rgqb_pkg::DRAW_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_INIT, S_FIX, S_SCAN, S_SUM, S_MUL, S_DONE
    } state_t;

    logic [WEIGHT_BITS-1:0] wmem [WDEPTH];
    logic [2*GAIN_W-1:0]    gmem [GDEPTH];
    logic [WEIGHT_BITS-1:0] wmem_q;
    logic [2*GAIN_W-1:0]    gmem_q;

    logic                   wm_we, gm_we;
    logic [WADDR_W-1:0]     wm_waddr, wm_raddr;
    logic [WEIGHT_BITS-1:0] wm_wdata;
    logic [IDX_W-1:0]       gm_waddr, gm_raddr;
    logic [2*GAIN_W-1:0]    gm_wdata;

    always_ff @(posedge aclk) begin
        if (wm_we) begin
            wmem[wm_waddr] <= wm_wdata;
        end
        wmem_q <= wmem[wm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (gm_we) begin
            gmem[gm_waddr] <= gm_wdata;
        end
        gmem_q <= gmem[gm_raddr];
    end

    state_t state_reg, state_next;
    logic [WADDR_W-1:0] clr_reg, clr_next;
    logic [rgqb_pkg::CFG_W-1:0] prob_reg, prob_next;
    logic [CNT_W-1:0] act_n_reg, act_n_next, rem_reg, rem_next;
    logic [MAX_VARS-1:0] flags_reg, flags_next;
    logic [IDX_W-1:0] ri_reg, ri_next, rj_reg, rj_next;
    logic iss_done_reg, iss_done_next, pv_reg, pv_next;
    logic [IDX_W-1:0] pi_reg, pi_next, pj_reg, pj_next;
    logic signed [GAIN_W-1:0] sum_reg, sum_next, diag_reg, diag_next;
    logic [IDX_W-1:0] fk_reg, fk_next;
    logic fv_reg, fv_next;
    logic [rgqb_pkg::DRAW_W-1:0] draw_reg, draw_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [GAIN_W-1:0] g0m_reg, g0m_next, g1m_reg, g1m_next;
    logic signed [S_W-1:0] s_reg, s_next;
    logic [rgqb_pkg::FIELD_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic res_val_reg, res_val_next, res_fin_reg, res_fin_next, res_acc_reg, res_acc_next;
    logic m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next, m_tuser_reg, m_tuser_next;
    logic [rgqb_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    rgqb_pkg::func_t in_func;
    logic [rgqb_pkg::FIELD_IDX_W-1:0] in_row, in_col, in_sidx;
    logic [rgqb_pkg::IN_WGT_W-1:0] in_weight;
    logic in_sval;
    logic [rgqb_pkg::DRAW_W-1:0] in_draw;
    logic [31:0] row_ext, col_ext, sidx_ext, wgt_ext, fk_ext;
    logic [CNT_W-1:0] cfg_n, nm1;
    logic signed [GAIN_W-1:0] w_g, d_g, sum_now, diag_now, g0_q, g1_q;
    logic signed [P_W-1:0] prod_w, rhs_w;
    logic is_diag, pick_zero, s_hand;

    assign in_func   = rgqb_pkg::func_t'(s_tuser);
    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_weight = s_tdata[27:12];
    assign in_sidx   = s_tdata[33:28];
    assign in_sval   = s_tdata[34];
    assign in_draw   = s_tdata[50:35];

    assign row_ext  = 32'(in_row);
    assign col_ext  = 32'(in_col);
    assign sidx_ext = 32'(in_sidx);
    assign wgt_ext  = 32'(in_weight);
    assign fk_ext   = 32'(fk_reg);

    assign cfg_n = (32'(prob_reg) > MAX_VARS) ? CNT_W'(MAX_VARS) : CNT_W'(prob_reg);
    assign nm1   = act_n_reg - CNT_W'(1);

    assign w_g      = GAIN_W'($signed(wmem_q));
    assign d_g      = w_g <<< 1;
    assign g0_q     = $signed(gmem_q[GAIN_W-1:0]);
    assign g1_q     = $signed(gmem_q[2*GAIN_W-1:GAIN_W]);
    assign is_diag  = (pi_reg == pj_reg);
    assign sum_now  = is_diag ? sum_reg : sum_reg + w_g;
    assign diag_now = is_diag ? w_g : diag_reg;

    assign prod_w    = $signed({1'b0, draw_reg}) * s_reg;
    assign rhs_w     = P_W'(g0m_reg) <<< 16;
    assign pick_zero = (s_reg > 0) ? (prod_w < rhs_w) : !draw_reg[15];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_hand    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        prob_next     = cfg_valid ? cfg_data : prob_reg;
        act_n_next    = act_n_reg;
        rem_next      = rem_reg;
        flags_next    = flags_reg;
        ri_next       = ri_reg;
        rj_next       = rj_reg;
        iss_done_next = iss_done_reg;
        pv_next       = pv_reg;
        pi_next       = ri_reg;
        pj_next       = rj_reg;
        sum_next      = sum_reg;
        diag_next     = diag_reg;
        fk_next       = fk_reg;
        fv_next       = fv_reg;
        draw_next     = draw_reg;
        found_next    = found_reg;
        k0_next       = k0_reg;
        k1_next       = k1_reg;
        g0m_next      = g0m_reg;
        g1m_next      = g1m_reg;
        s_next        = s_reg;
        res_idx_next  = res_idx_reg;
        res_val_next  = res_val_reg;
        res_fin_next  = res_fin_reg;
        res_acc_next  = res_acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        wm_we    = 1'b0;
        wm_waddr = clr_reg;
        wm_wdata = '0;
        wm_raddr = (state_reg == S_INIT) ? {ri_reg, rj_reg} : {ri_reg, fk_reg};
        gm_we    = 1'b0;
        gm_waddr = pi_reg;
        gm_wdata = {g1_q - d_g, g0_q + d_g};
        gm_raddr = ri_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                wm_we    = 1'b1;
                clr_next = clr_reg + WADDR_W'(1);
                if (clr_reg == WADDR_W'(WDEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_hand) begin
                    res_idx_next = '0;
                    res_val_next = 1'b0;
                    res_fin_next = 1'b0;
                    res_acc_next = 1'b0;
                    state_next   = S_DONE;
                    ri_next       = '0;
                    rj_next       = '0;
                    iss_done_next = 1'b0;
                    pv_next       = 1'b0;
                    sum_next      = '0;
                    diag_next     = '0;
                    found_next    = 1'b0;
                    unique case (in_func)
                        rgqb_pkg::FUNC_WRITE: begin
                            if (row_ext < MAX_VARS && col_ext < MAX_VARS) begin
                                wm_we        = 1'b1;
                                wm_waddr     = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
                                wm_wdata     = wgt_ext[WEIGHT_BITS-1:0];
                                res_acc_next = 1'b1;
                            end
                        end
                        rgqb_pkg::FUNC_START: begin
                            if (cfg_n != '0 && sidx_ext < 32'(cfg_n)) begin
                                act_n_next = cfg_n;
                                rem_next   = cfg_n;
                                flags_next = '0;
                                fk_next    = sidx_ext[IDX_W-1:0];
                                fv_next    = in_sval;
                                state_next = S_INIT;
                            end
                        end
                        rgqb_pkg::FUNC_STEP: begin
                            if (rem_reg != '0) begin
                                draw_next  = in_draw;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INIT: begin
                pv_next = !iss_done_reg;
                if (!iss_done_reg) begin
                    if (CNT_W'(rj_reg) == nm1) begin
                        rj_next = '0;
                        ri_next = ri_reg + IDX_W'(1);
                        if (CNT_W'(ri_reg) == nm1) begin
                            iss_done_next = 1'b1;
                        end
                    end else begin
                        rj_next = rj_reg + IDX_W'(1);
                    end
                end
                if (pv_reg) begin
                    if (CNT_W'(pj_reg) == nm1) begin
                        gm_we     = 1'b1;
                        gm_wdata  = {GAIN_W'(3 * diag_now + 2 * sum_now),
                                     GAIN_W'(-diag_now - 2 * sum_now)};
                        sum_next  = '0;
                        diag_next = '0;
                        if (CNT_W'(pi_reg) == nm1) begin
                            state_next    = S_FIX;
                            ri_next       = '0;
                            iss_done_next = 1'b0;
                            pv_next       = 1'b0;
                        end
                    end else begin
                        sum_next  = sum_now;
                        diag_next = diag_now;
                    end
                end
            end
            S_FIX, S_SCAN: begin
                pv_next = !iss_done_reg;
                if (!iss_done_reg) begin
                    ri_next = ri_reg + IDX_W'(1);
                    if (CNT_W'(ri_reg) == nm1) begin
                        iss_done_next = 1'b1;
                    end
                end
                if (pv_reg && state_reg == S_FIX) begin
                    gm_we = (pi_reg != fk_reg);
                    if (fv_reg) begin
                        gm_wdata = {g1_q + d_g, g0_q - d_g};
                    end
                    if (CNT_W'(pi_reg) == nm1) begin
                        flags_next[fk_reg] = 1'b1;
                        rem_next     = rem_reg - CNT_W'(1);
                        res_idx_next = fk_ext[rgqb_pkg::FIELD_IDX_W-1:0];
                        res_val_next = fv_reg;
                        res_fin_next = (rem_reg == CNT_W'(1));
                        res_acc_next = 1'b1;
                        state_next   = S_DONE;
                    end
                end
                if (pv_reg && state_reg == S_SCAN) begin
                    if (!flags_reg[pi_reg]) begin
                        found_next = 1'b1;
                        if (!found_reg || g0_q > g0m_reg) begin
                            k0_next  = pi_reg;
                            g0m_next = g0_q;
                        end
                        if (!found_reg || g1_q > g1m_reg) begin
                            k1_next  = pi_reg;
                            g1m_next = g1_q;
                        end
                    end
                    if (CNT_W'(pi_reg) == nm1) begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                s_next = S_W'(g0m_reg) + S_W'(g1m_reg);
                if (found_reg) begin
                    state_next = S_MUL;
                end else begin
                    rem_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_MUL: begin
                fk_next       = pick_zero ? k0_reg : k1_reg;
                fv_next       = !pick_zero;
                ri_next       = '0;
                iss_done_next = 1'b0;
                pv_next       = 1'b0;
                state_next    = S_FIX;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_val_reg, res_idx_reg};
                    m_tlast_next  = res_fin_reg;
                    m_tuser_next  = res_acc_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            prob_reg     <= rgqb_pkg::SIZE_RESET;
            act_n_reg    <= '0;
            rem_reg      <= '0;
            flags_reg    <= '0;
            iss_done_reg <= 1'b0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            prob_reg     <= prob_next;
            act_n_reg    <= act_n_next;
            rem_reg      <= rem_next;
            flags_reg    <= flags_next;
            iss_done_reg <= iss_done_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ri_reg      <= ri_next;
        rj_reg      <= rj_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        sum_reg     <= sum_next;
        diag_reg    <= diag_next;
        fk_reg      <= fk_next;
        fv_reg      <= fv_next;
        draw_reg    <= draw_next;
        found_reg   <= found_next;
        k0_reg      <= k0_next;
        k1_reg      <= k1_next;
        g0m_reg     <= g0m_next;
        g1m_reg     <= g1m_next;
        s_reg       <= s_next;
        res_idx_reg <= res_idx_next;
        res_val_reg <= res_val_next;
        res_fin_reg <= res_fin_next;
        res_acc_reg <= res_acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
`default_nettype wire

[rtl/rgqb_checker.sv]
`default_nettype none
module rgqb_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [rgqb_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire                             m_tlast,
    input wire [0:0]                       m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tlast)
        else $error("ignored command carries nonzero result");

    a_last_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("finished flag on an ignored command");

endmodule

bind randomized_greedy_qubo_builder_top rgqb_checker u_rgqb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[tb/sv/tb_randomized_greedy_qubo_builder_top.sv]
`default_nettype none
module tb_randomized_greedy_qubo_builder_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0] idx;
        logic       val;
        logic       fin;
        logic       acc;
    } qubo_result_t;

    class qubo_scoreboard;
        int unsigned size_reg;
        int unsigned active_n;
        int unsigned remaining;
        logic signed [15:0] wmem [64*64];
        longint g0 [64];
        longint g1 [64];
        bit fixed [64];
        qubo_result_t pending [$];
        int errors;

        function void clear();
            size_reg = 64;
            active_n = 0;
            remaining = 0;
            errors = 0;
            for (int i = 0; i < 4096; i++) wmem[i] = '0;
            for (int i = 0; i < 64; i++) begin
                g0[i] = 0;
                g1[i] = 0;
                fixed[i] = 0;
            end
        endfunction

        function void fix_var(int unsigned k, bit v);
            longint d;
            for (int unsigned i = 0; i < active_n; i++) begin
                if (i != k) begin
                    d = 2 * longint'(wmem[i*64 + k]);
                    if (v) begin
                        g0[i] -= d;
                        g1[i] += d;
                    end else begin
                        g0[i] += d;
                        g1[i] -= d;
                    end
                end
            end
            fixed[k] = 1;
            if (remaining > 0) remaining--;
        endfunction

        function void note_input(rgqb_pkg::func_t f, logic [5:0] row, logic [5:0] col,
                                 logic signed [15:0] w, logic [5:0] sidx,
                                 logic sval, logic [15:0] draw);
            qubo_result_t r;
            int unsigned n, k0, k1;
            longint s, diag, gsum;
            bit found, zero;
            r = '0;
            case (f)
                rgqb_pkg::FUNC_WRITE: begin
                    wmem[row*64 + col] = w;
                    r.acc = 1;
                end
                rgqb_pkg::FUNC_START: begin
                    n = size_reg > 64 ? 64 : size_reg;
                    if (n != 0 && sidx < n) begin
                        active_n = n;
                        for (int unsigned i = 0; i < n; i++) begin
                            diag = wmem[i*64 + i];
                            gsum = 0;
                            for (int unsigned j = 0; j < n; j++)
                                if (j != i) gsum += wmem[i*64 + j];
                            g0[i] = -diag - 2*gsum;
                            g1[i] = 3*diag + 2*gsum;
                            fixed[i] = 0;
                        end
                        remaining = n;
                        fix_var(sidx, sval);
                        r.idx = sidx;
                        r.val = sval;
                        r.fin = remaining == 0;
                        r.acc = 1;
                    end
                end
                rgqb_pkg::FUNC_STEP: begin
                    if (remaining != 0) begin
                        found = 0;
                        k0 = 0;
                        k1 = 0;
                        for (int unsigned i = 0; i < active_n; i++) begin
                            if (!fixed[i]) begin
                                if (!found) begin
                                    k0 = i;
                                    k1 = i;
                                    found = 1;
                                end else begin
                                    if (g0[i] > g0[k0]) k0 = i;
                                    if (g1[i] > g1[k1]) k1 = i;
                                end
                            end
                        end
                        if (!found) begin
                            remaining = 0;
                        end else begin
                            s = g0[k0] + g1[k1];
                            if (s <= 0) zero = draw < 32768;
                            else zero = longint'(draw) * s < 65536 * g0[k0];
                            if (zero) begin
                                fix_var(k0, 0);
                                r.idx = k0[5:0];
                            end else begin
                                fix_var(k1, 1);
                                r.idx = k1[5:0];
                                r.val = 1;
                            end
                            r.fin = remaining == 0;
                            r.acc = 1;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(qubo_result_t got);
            qubo_result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.idx !== exp.idx) begin
                $display("%0t: chosen_index exp %0d got %0d", $time, exp.idx, got.idx);
                errors++;
            end
            if (got.val !== exp.val) begin
                $display("%0t: chosen_value exp %0d got %0d", $time, exp.val, got.val);
                errors++;
            end
            if (got.fin !== exp.fin) begin
                $display("%0t: finished exp %0d got %0d", $time, exp.fin, got.fin);
                errors++;
            end
            if (got.acc !== exp.acc) begin
                $display("%0t: accepted exp %0d got %0d", $time, exp.acc, got.acc);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [rgqb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [rgqb_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic [0:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [rgqb_pkg::CFG_W-1:0] cfg_data = '0;

    qubo_scoreboard board;
    bit stall_go = 0;
    bit long_stall = 0;
    int rx_wait = 0;
    int rx_gap;
    int unsigned cur_size = 64;

    randomized_greedy_qubo_builder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    task automatic send_cmd(rgqb_pkg::func_t f, logic [5:0] row, logic [5:0] col,
                            logic [15:0] w, logic [5:0] sidx, logic sval,
                            logic [15:0] draw);
        int gap;
        s_tvalid <= 1;
        s_tuser <= f;
        s_tdata <= {5'b0, draw, sval, sidx, w, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(f, row, col, w, sidx, sval, draw);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_w(logic [5:0] r, logic [5:0] c, logic [15:0] w);
        send_cmd(rgqb_pkg::FUNC_WRITE, r, c, w, 6'($urandom), 1'($urandom),
                 16'($urandom));
    endtask

    task automatic start_cmd(logic [5:0] idx, logic v);
        send_cmd(rgqb_pkg::FUNC_START, 6'($urandom), 6'($urandom), 16'($urandom), idx, v,
                 16'($urandom));
    endtask

    task automatic step_cmd(logic [15:0] draw);
        send_cmd(rgqb_pkg::FUNC_STEP, 6'($urandom), 6'($urandom), 16'($urandom),
                 6'($urandom), 1'($urandom), draw);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_size(logic [6:0] n);
        drain();
        repeat (64*64 + 64 + 20) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        board.size_reg = n;
        cur_size = n > 64 ? 64 : n;
    endtask

    task automatic build_run(int unsigned n_w);
        int unsigned lim;
        lim = cur_size == 0 ? 1 : cur_size;
        repeat (n_w) write_w(6'($urandom_range(0, lim - 1)), 6'($urandom_range(0, lim - 1)),
                             16'($urandom));
        start_cmd(6'($urandom_range(0, lim - 1)), 1'($urandom));
        repeat (lim + $urandom_range(0, 1)) begin
            if ($urandom_range(0, 4) == 0) step_cmd(16'($urandom_range(32760, 32775)));
            else step_cmd(16'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready)
                board.check_result('{idx: m_tdata[5:0], val: m_tdata[6], fin: m_tlast,
                                     acc: m_tuser[0]});
            if (long_stall) begin
                m_tready <= 0;
            end else if (m_tvalid && m_tready) begin
                rx_gap = $urandom_range(0, 11);
                rx_wait <= rx_gap;
                m_tready <= (rx_gap == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1;
            end
        end
    end

    initial begin
        wait (stall_go);
        @(posedge aclk);
        long_stall <= 1;
        repeat (300) @(posedge aclk);
        long_stall <= 0;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        board = new();
        board.clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, each command, ignored cases
        step_cmd(16'hffff);
        send_cmd(rgqb_pkg::FUNC_NONE, 6'h3f, 6'h3f, 16'hffff, 6'h3f, 1, 16'hffff);
        write_w(0, 0, 16'h7fff);
        write_w(63, 63, 16'h8000);
        write_w(0, 63, 16'hffff);
        write_w(63, 0, 16'h0001);
        write_w(1, 2, 16'h5555);
        write_w(2, 1, 16'haaaa);
        start_cmd(63, 1);
        step_cmd(0);
        step_cmd(16'hffff);
        step_cmd(16'h8000);
        step_cmd(16'h7fff);
        set_size(0);
        start_cmd(0, 0);
        set_size(127);
        start_cmd(5, 0);
        set_size(1);
        start_cmd(1, 0);
        start_cmd(0, 1);
        step_cmd(0);
        set_size(3);
        start_cmd(2, 0);
        step_cmd(0);
        write_w(0, 1, 16'h1234);
        start_cmd(1, 1);
        step_cmd(16'hffff);
        step_cmd(0);
        step_cmd(0);

        // receiver stalls long while inputs keep arriving
        stall_go = 1;
        repeat (12) write_w(6'($urandom_range(0, 2)), 6'($urandom_range(0, 2)),
                            16'($urandom));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_size(8);
                1: set_size(64);
                2: set_size(2);
                3: set_size(7'($urandom_range(4, 16)));
                4: set_size(100);
                default: set_size(7'($urandom_range(1, 12)));
            endcase
            for (int r = 0; r < 9 && ph != 1 && ph != 4; r++)
                build_run($urandom_range(4, 20));
            if (ph == 1 || ph == 4) build_run(80);
            repeat (3) send_cmd(rgqb_pkg::func_t'($urandom_range(0, 3)), 6'($urandom),
                                6'($urandom), 16'($urandom), 6'($urandom), 1'($urandom),
                                16'($urandom));
        end
        set_size(12);
        for (int k = 0; k < 12; k++) build_run($urandom_range(6, 20));
        drain();
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

[randomized_greedy_qubo_builder_top.f]
rtl/rgqb_pkg.sv
rtl/randomized_greedy_qubo_builder_top.sv
rtl/rgqb_checker.sv
tb/sv/tb_randomized_greedy_qubo_builder_top.sv
